[src/bprm_pkg.sv]
`timescale 1ns / 1ps

package bprm_pkg;

  // Table geometry
  localparam int RULES  = 32;
  localparam int ADDR_W = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int CNT_W  = $clog2(RULES + 1);

  // Field widths
  localparam int OP_W    = 2;
  localparam int PORT_W  = 3;
  localparam int PIN_W   = 3;
  localparam int TICKS_W = 8;
  localparam int SLOT_W  = 5;
  localparam int BYTE_W  = 8;
  localparam int KEY_W   = PORT_W + PIN_W;
  localparam int ENTRY_W = 2 * BYTE_W;

  // Trigger byte layout
  localparam int TRIG_LONG_BIT = 7;
  localparam int TRIG_MED_BIT  = 6;

  // Opcodes
  localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
  localparam logic [OP_W-1:0] OP_HELD     = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASED = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS   = 2'd3;
  localparam int CFG_DATA_W = 8;
  localparam int RULE_COUNT_W = 6;

  // Register reset values
  localparam logic [TICKS_W-1:0] SHORT_TICKS_RST  = 8'd1;
  localparam logic [TICKS_W-1:0] MEDIUM_TICKS_RST = 8'd25;
  localparam logic [TICKS_W-1:0] LONG_TICKS_RST   = 8'd100;

  typedef enum logic [1:0] {
    CLASS_NONE   = 2'd0,
    CLASS_SHORT  = 2'd1,
    CLASS_MEDIUM = 2'd2,
    CLASS_LONG   = 2'd3
  } press_class_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } seq_state_t;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [PORT_W-1:0]  port;
    logic [PIN_W-1:0]   pin;
    logic [TICKS_W-1:0] ticks;
    logic [SLOT_W-1:0]  rule_slot;
    logic [BYTE_W-1:0]  rule_trigger;
    logic [BYTE_W-1:0]  rule_action;
  } in_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] action;
  } out_rsp_t;

  // Result of comparing one stored rule against the current request
  typedef struct packed {
    logic              trig_zero;
    logic              key_hit;
    logic              exact_hit;
    logic              loose_hit;
    logic [BYTE_W-1:0] action;
  } match_t;

  function automatic press_class_t class_of_ticks(
    input logic [TICKS_W-1:0] t,
    input logic [TICKS_W-1:0] short_t,
    input logic [TICKS_W-1:0] medium_t,
    input logic [TICKS_W-1:0] long_t
  );
    press_class_t c;
    if (t >= long_t) c = CLASS_LONG;
    else if (t >= medium_t) c = CLASS_MEDIUM;
    else if (t >= short_t) c = CLASS_SHORT;
    else c = CLASS_NONE;
    return c;
  endfunction

endpackage

[src/bprm_chan_if.sv]
`timescale 1ns / 1ps

interface bprm_in_if import bprm_pkg::*; ();
  logic    valid;
  logic    ready;
  in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bprm_out_if import bprm_pkg::*; ();
  logic     valid;
  logic     ready;
  out_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/button_press_rule_matcher.sv]
`timescale 1ns / 1ps

// Button press rule matcher.
// Requests arrive on in_req (valid/ready). A load request writes one rule
// (trigger byte, action byte) into the rule table and gives no response.
// A held or released request classes its tick count against the short,
// medium and long thresholds and scans the table for rules of its port and
// pin; exactly one response carrying the action byte (0 if nothing fits)
// leaves on out_rsp. Opcode 3 is taken and dropped.
// Timing: a query scans one rule per cycle through a single comparator fed
// by the table's registered read port, judging at most RULES rules (32
// here); the response register is loaded as the deciding rule is judged.
// A query with a rule count of zero answers in the cycle after acceptance.
// in_req.ready is low while a scan runs, and also while an earlier response
// waits in the output register and out_rsp.ready is low: a stalled receiver
// holds the block. Configuration writes (cfg_we/cfg_index/cfg_wdata) are
// taken at any edge and must only happen while the block is idle.
// Reset clears the sequencer state, the output valid flag and the rule
// count and restores the tick thresholds; the rule table is not cleared
// and must be loaded before use.
module button_press_rule_matcher import bprm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bprm_in_if.sink               in_req,
  bprm_out_if.source            out_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [RULE_COUNT_W-1:0] rule_count_r;
  logic [TICKS_W-1:0]      short_ticks_r;
  logic [TICKS_W-1:0]      medium_ticks_r;
  logic [TICKS_W-1:0]      long_ticks_r;

  // Sequencer registers
  seq_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  press_class_t      press_r, press_nxt;
  logic              rel_r, rel_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_action_r, out_action_nxt;

  logic              accept;
  logic              is_query;
  logic [CNT_W-1:0]  n_lim;
  logic              last;
  logic              scan_done;
  logic [BYTE_W-1:0] scan_action;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  match_t            hit;

  assign in_req.ready = (state_r == ST_IDLE) && (!out_valid_r || out_rsp.ready);
  assign accept       = in_req.valid && in_req.ready;
  assign is_query     = (in_req.data.opcode == OP_HELD) ||
                        (in_req.data.opcode == OP_RELEASED);

  // Clamp the rule count to the table size
  assign n_lim = (32'(rule_count_r) > RULES) ? CNT_W'(RULES) : CNT_W'(rule_count_r);

  // Drop loads to slots outside the table
  assign mem_we = accept && (in_req.data.opcode == OP_LOAD) &&
                  (32'(in_req.data.rule_slot) < RULES);

  bprm_rule_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ADDR_W'(in_req.data.rule_slot)),
    .wdata ({in_req.data.rule_trigger, in_req.data.rule_action}),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bprm_match u_match (
    .entry  (mem_rdata),
    .key    (key_r),
    .press  (press_r),
    .result (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r   <= '0;
      short_ticks_r  <= SHORT_TICKS_RST;
      medium_ticks_r <= MEDIUM_TICKS_RST;
      long_ticks_r   <= LONG_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RULE_COUNT:   rule_count_r   <= cfg_wdata[RULE_COUNT_W-1:0];
        CFG_SHORT_TICKS:  short_ticks_r  <= cfg_wdata[TICKS_W-1:0];
        CFG_MEDIUM_TICKS: medium_ticks_r <= cfg_wdata[TICKS_W-1:0];
        CFG_LONG_TICKS:   long_ticks_r   <= cfg_wdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // The current rule is the last one allowed by the count
  assign last = (CNT_W'(k_r) + CNT_W'(1)) >= n_r;

  // Decide on the rule in the read register
  always_comb begin
    scan_done   = 1'b0;
    scan_action = '0;
    found_nxt   = found_r;
    if ((k_r == '0) && hit.trig_zero) begin
      // empty table marker in entry 0
      scan_done = 1'b1;
    end else if (hit.key_hit) begin
      found_nxt = 1'b1;
      if (!rel_r) begin
        scan_done   = 1'b1;
        scan_action = hit.exact_hit ? hit.action : '0;
      end else if (hit.exact_hit || hit.loose_hit) begin
        scan_done   = 1'b1;
        scan_action = hit.action;
      end else begin
        scan_done = last;
      end
    end else begin
      // end of the pin's run, or end of the table
      scan_done = found_r || last;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_query && (n_lim != '0)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs and datapath updates
  always_comb begin
    k_nxt          = k_r;
    n_nxt          = n_r;
    key_nxt        = key_r;
    press_nxt      = press_r;
    rel_nxt        = rel_r;
    mem_raddr      = '0;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_action_nxt = out_action_r;
    case (state_r)
      ST_IDLE: begin
        mem_raddr = '0;
        if (accept && is_query) begin
          k_nxt     = '0;
          n_nxt     = n_lim;
          key_nxt   = {in_req.data.port, in_req.data.pin};
          press_nxt = class_of_ticks(in_req.data.ticks, short_ticks_r,
                                     medium_ticks_r, long_ticks_r);
          rel_nxt   = (in_req.data.opcode == OP_RELEASED);
          if (n_lim == '0) begin
            out_valid_nxt  = 1'b1;
            out_action_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        // prefetch the next rule while this one is judged
        mem_raddr = k_r + ADDR_W'(1);
        k_nxt     = k_r + ADDR_W'(1);
        if (scan_done) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = scan_action;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      // clear the run flag when a query starts
      found_r     <= (state_r == ST_IDLE) ? 1'b0 : found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    n_r          <= n_nxt;
    key_r        <= key_nxt;
    press_r      <= press_nxt;
    rel_r        <= rel_nxt;
    out_action_r <= out_action_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.data.action = out_action_r;

endmodule

[src/bprm_rule_mem.sv]
`timescale 1ns / 1ps

module bprm_rule_mem import bprm_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [RULES];
  logic [ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read: data appears the cycle after the address
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/bprm_match.sv]
`timescale 1ns / 1ps

module bprm_match import bprm_pkg::*; (
  input  logic [ENTRY_W-1:0] entry,
  input  logic [KEY_W-1:0]   key,
  input  press_class_t       press,
  output match_t             result
);

  logic [BYTE_W-1:0] trig;
  press_class_t      rule_class;

  assign trig = entry[ENTRY_W-1:BYTE_W];

  always_comb begin
    if (trig[TRIG_LONG_BIT]) rule_class = CLASS_LONG;
    else if (trig[TRIG_MED_BIT]) rule_class = CLASS_MEDIUM;
    else rule_class = CLASS_SHORT;
  end

  always_comb begin
    result.trig_zero = (trig == '0);
    result.key_hit   = (trig[KEY_W-1:0] == key);
    result.exact_hit = (rule_class == press);
    // a short rule also answers a medium release
    result.loose_hit = (rule_class == CLASS_SHORT) && (press == CLASS_MEDIUM);
    result.action    = entry[BYTE_W-1:0];
  end

endmodule

[test/button_press_rule_matcher_tb.sv]
`timescale 1ns / 1ps

module button_press_rule_matcher_tb;
  import bprm_pkg::*;

  // Opcode 3 is taken by the block and dropped; the package has no name for it
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam int RAND_ITEMS   = 1150;
  localparam int CALM_ITEMS   = 150;     // tail of the run with no idling at all
  localparam int DRAIN_CYCLES = RULES + 8;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {
    ROW_PREDICT,   // request whose response comes from the predictor
    ROW_TYPED,     // request whose response is written into the row
    ROW_CFG        // register write, done only once the block is idle
  } row_kind_t;

  typedef struct {
    row_kind_t               kind;
    in_req_t                 req;
    logic [BYTE_W-1:0]       want;
    logic [CFG_IDX_W-1:0]    cfg_idx;
    logic [CFG_DATA_W-1:0]   cfg_val;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bprm_in_if  in_req ();
  bprm_out_if out_rsp ();

  button_press_rule_matcher u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block: rule table, registers and the actions still owed
  logic [BYTE_W-1:0]       trig_mem [RULES];
  logic [BYTE_W-1:0]       act_mem  [RULES];
  logic [RULE_COUNT_W-1:0] rule_count_r;
  logic [TICKS_W-1:0]      short_thr;
  logic [TICKS_W-1:0]      medium_thr;
  logic [TICKS_W-1:0]      long_thr;
  logic [BYTE_W-1:0]       pending_actions [$];

  // Keys that the current phase builds its rules around
  logic [KEY_W-1:0] key_pool [3];
  int               pool_size;

  // Idling controls, changed per phase
  bit calm;
  int stall_pct;
  int gap_pct;

  int err_count;
  int cycle_count;
  int n_checked;
  int n_held;
  int n_released;
  int n_loads;
  int n_phases;
  int rand_items;

  dir_row_t dir_rows [$];

  // -------------------------------------------------------------------------
  // Clock and cycle watchdog
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses still owed",
               cycle_count, pending_actions.size());
      $display("button_press_rule_matcher_tb failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------
  function automatic press_class_t tick_class(input logic [TICKS_W-1:0] t);
    if (t >= long_thr) return CLASS_LONG;
    if (t >= medium_thr) return CLASS_MEDIUM;
    if (t >= short_thr) return CLASS_SHORT;
    return CLASS_NONE;
  endfunction

  // Long wins over medium; a trigger with neither bit is a short rule
  function automatic press_class_t rule_class(input logic [BYTE_W-1:0] trig);
    if (trig[TRIG_LONG_BIT]) return CLASS_LONG;
    if (trig[TRIG_MED_BIT]) return CLASS_MEDIUM;
    return CLASS_SHORT;
  endfunction

  // Action the block owes for a held or released request
  function automatic logic [BYTE_W-1:0] lookup_action(input logic released,
                                                      input logic [KEY_W-1:0] key,
                                                      input logic [TICKS_W-1:0] t);
    int n;
    int k;
    press_class_t press;
    press_class_t rc;
    n = (int'(rule_count_r) > RULES) ? RULES : int'(rule_count_r);
    press = tick_class(t);
    // an empty table, or a zero trigger in entry 0, answers nothing
    if (n == 0 || trig_mem[0] == '0) return '0;
    k = 0;
    while (k < n && trig_mem[k][KEY_W-1:0] != key) k++;
    if (k >= n) return '0;
    // held: only the first rule for the pin counts, and only an exact class
    if (!released) return (rule_class(trig_mem[k]) == press) ? act_mem[k] : '0;
    // released: walk the run of rules for this pin; a short rule also
    // answers a medium press
    while (k < n && trig_mem[k][KEY_W-1:0] == key) begin
      rc = rule_class(trig_mem[k]);
      if (rc == press || (rc == CLASS_SHORT && press == CLASS_MEDIUM)) return act_mem[k];
      k++;
    end
    return '0;
  endfunction

  // -------------------------------------------------------------------------
  // Response checking
  // -------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  always @(posedge clk) begin : rsp_check
    logic [BYTE_W-1:0] want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (pending_actions.size() == 0) begin
        report_mismatch($sformatf("action 0x%02h with no request waiting",
                                  out_rsp.data.action));
      end else begin
        want = pending_actions.pop_front();
        n_checked++;
        if (out_rsp.data.action !== want)
          report_mismatch($sformatf("action got 0x%02h want 0x%02h",
                                    out_rsp.data.action, want));
      end
    end
  end

  // Receiver: stall in random bursts, never once the run turns calm
  initial begin : rsp_ready
    int stall_left;
    stall_left = 0;
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        out_rsp.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 4);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Driving
  // -------------------------------------------------------------------------
  // Offer one request from a falling edge, hold it until taken, then fold it
  // into the shadow state. Returns on the falling edge after acceptance.
  task automatic send_req(input in_req_t r, input logic typed, input logic [BYTE_W-1:0] want);
    in_req.valid <= 1'b1;
    in_req.data  <= r;
    do @(posedge clk); while (!in_req.ready);
    case (r.opcode)
      OP_LOAD: begin
        trig_mem[r.rule_slot] = r.rule_trigger;
        act_mem[r.rule_slot]  = r.rule_action;
        n_loads++;
      end
      OP_HELD, OP_RELEASED: begin
        pending_actions.push_back(typed ? want :
          lookup_action(r.opcode == OP_RELEASED, {r.port, r.pin}, r.ticks));
        if (r.opcode == OP_HELD) n_held++;
        else n_released++;
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Drop valid for a random burst before the next request
  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 4);
      in_req.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Wait until every owed action has come back, then let a trailing load
  // or dropped request clear the block
  task automatic wait_idle();
    in_req.valid <= 1'b0;
    while (pending_actions.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RULE_COUNT:   rule_count_r = val[RULE_COUNT_W-1:0];
      CFG_SHORT_TICKS:  short_thr    = val;
      CFG_MEDIUM_TICKS: medium_thr   = val;
      CFG_LONG_TICKS:   long_thr     = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic dir_row_t mk_req(input row_kind_t kind, input logic [OP_W-1:0] op,
                                      input int port,
                                      input int pin,
                                      input int ticks,
                                      input int slot,
                                      input logic [BYTE_W-1:0] trig,
                                      input logic [BYTE_W-1:0] act,
                                      input logic [BYTE_W-1:0] want);
    dir_row_t row;
    row.kind             = kind;
    row.req.opcode       = op;
    row.req.port         = PORT_W'(port);
    row.req.pin          = PIN_W'(pin);
    row.req.ticks        = TICKS_W'(ticks);
    row.req.rule_slot    = SLOT_W'(slot);
    row.req.rule_trigger = trig;
    row.req.rule_action  = act;
    row.want             = want;
    row.cfg_idx          = '0;
    row.cfg_val          = '0;
    return row;
  endfunction

  function automatic dir_row_t mk_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row.kind    = ROW_CFG;
    row.req     = '0;
    row.want    = '0;
    row.cfg_idx = idx;
    row.cfg_val = val;
    return row;
  endfunction

  function automatic in_req_t random_req();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(in_req_t)-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, pool_size - 1)];
    return KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
  endfunction

  // Aim the tick count at a threshold edge half of the time
  function automatic logic [TICKS_W-1:0] pick_ticks();
    logic [TICKS_W-1:0] base;
    case ($urandom_range(0, 5))
      0: base = short_thr;
      1: base = medium_thr;
      2: base = long_thr;
      3: return $urandom_range(0, 1) ? '1 : '0;
      default: return TICKS_W'($urandom_range(0, 255));
    endcase
    return base + TICKS_W'($urandom_range(0, 2)) - TICKS_W'(1);
  endfunction

  // One random phase: new registers, a fresh table over every valid slot,
  // then a run of queries mixed with stray loads and dropped requests
  task automatic random_phase();
    logic [CFG_DATA_W-1:0] cnt_val;
    int s;
    int m;
    int l;
    int n_eff;
    int n_q;
    int k;
    int slot;
    bit desc;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] prev_key;
    in_req_t r;

    n_phases++;
    case ($urandom_range(0, 9))
      0:       cnt_val = '0;
      1:       cnt_val = CFG_DATA_W'(RULES);
      2:       cnt_val = CFG_DATA_W'($urandom_range(RULES + 1, (1 << RULE_COUNT_W) - 1));
      default: cnt_val = CFG_DATA_W'($urandom_range(1, 8));
    endcase
    // upper data bits land outside the count register
    cnt_val[CFG_DATA_W-1:RULE_COUNT_W] = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: begin
        s = $urandom_range(0, 40);
        m = s + $urandom_range(0, 60);
        l = m + $urandom_range(0, 150);
        if (l > 255) l = 255;
      end
      1: begin
        s = $urandom_range(0, 1) ? 255 : 0;
        m = $urandom_range(0, 1) ? 255 : 0;
        l = $urandom_range(0, 1) ? 255 : 0;
      end
      default: begin
        s = $urandom_range(0, 255);
        m = $urandom_range(0, 255);
        l = $urandom_range(0, 255);
      end
    endcase
    write_reg(CFG_RULE_COUNT, cnt_val);
    write_reg(CFG_SHORT_TICKS, CFG_DATA_W'(s));
    write_reg(CFG_MEDIUM_TICKS, CFG_DATA_W'(m));
    write_reg(CFG_LONG_TICKS, CFG_DATA_W'(l));

    pool_size = $urandom_range(1, 3);
    for (k = 0; k < 3; k++) key_pool[k] = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
    // key zero with a short rule gives a zero trigger: the empty-table case
    if ($urandom_range(0, 9) == 0) key_pool[0] = '0;

    // Fill every slot the count makes valid, so no query reads an unloaded one
    n_eff = (int'(cnt_val[RULE_COUNT_W-1:0]) > RULES) ? RULES : int'(cnt_val[RULE_COUNT_W-1:0]);
    desc = $urandom_range(0, 1);
    prev_key = key_pool[0];
    for (k = 0; k < n_eff; k++) begin
      slot = desc ? n_eff - 1 - k : k;
      key = ($urandom_range(0, 9) < 6) ? prev_key : key_pool[$urandom_range(0, pool_size - 1)];
      prev_key = key;
      r = random_req();
      r.opcode       = OP_LOAD;
      r.rule_slot    = SLOT_W'(slot);
      r.rule_trigger = {2'($urandom_range(0, 3)), key};
      if ($urandom_range(0, 9) == 0) r.rule_trigger = BYTE_W'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) r.rule_action = '0;
      sender_gap();
      send_req(r, 1'b0, '0);
      rand_items++;
    end

    n_q = $urandom_range(12, 30);
    for (k = 0; k < n_q; k++) begin
      r = random_req();
      case ($urandom_range(0, 19))
        0: r.opcode = OP_SPARE;
        1: r.opcode = OP_LOAD;
        default: begin
          r.opcode = $urandom_range(0, 1) ? OP_HELD : OP_RELEASED;
          key = pick_key();
          r.port  = key[KEY_W-1:PIN_W];
          r.pin   = key[PIN_W-1:0];
          r.ticks = pick_ticks();
        end
      endcase
      sender_gap();
      send_req(r, 1'b0, '0);
      if (r.opcode != OP_SPARE) rand_items++;
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_req.valid  = 1'b0;
    in_req.data   = '0;
    rule_count_r  = '0;
    short_thr     = SHORT_TICKS_RST;
    medium_thr    = MEDIUM_TICKS_RST;
    long_thr      = LONG_TICKS_RST;
    calm          = 1'b0;
    stall_pct     = 20;
    gap_pct       = 20;
    pool_size     = 1;
    err_count     = 0;
    cycle_count   = 0;
    n_checked     = 0;
    n_held        = 0;
    n_released    = 0;
    n_loads       = 0;
    n_phases      = 0;
    rand_items    = 0;

    // Directed rows. Key port 1 pin 1 gets a short, a medium and a long rule
    // in a row; port 7 pin 7 gets one long rule with every trigger bit set.
    // Out of reset the count is zero: everything answers 0
    dir_rows.push_back(mk_req(ROW_TYPED, OP_HELD, 7, 7, 255, 31, 8'hFF, 8'hFF, 8'h00));
    dir_rows.push_back(mk_req(ROW_TYPED, OP_RELEASED, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_SPARE, 7, 7, 255, 31, 8'hFF, 8'hFF, 8'h00));
    // A zero trigger in entry 0 makes the table read as empty
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_LOAD, 0, 0, 0, 0, 8'h00, 8'hFF, 8'h00));
    dir_rows.push_back(mk_cfg(CFG_RULE_COUNT, 8'd1));
    dir_rows.push_back(mk_req(ROW_TYPED, OP_HELD, 0, 0, 255, 0, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_LOAD, 0, 0, 0, 0, 8'h09, 8'h11, 8'h00));
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_LOAD, 0, 0, 0, 1, 8'h49, 8'h22, 8'h00));
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_LOAD, 0, 0, 0, 2, 8'h89, 8'h33, 8'h00));
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_LOAD, 7, 7, 255, 3, 8'hFF, 8'hFF, 8'h00));
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_LOAD, 0, 0, 0, 31, 8'hC0, 8'h80, 8'h00));
    // Count of four, with the top data bits set and dropped
    dir_rows.push_back(mk_cfg(CFG_RULE_COUNT, 8'hC4));
    dir_rows.push_back(mk_req(ROW_TYPED, OP_HELD, 1, 1, 1, 0, 8'h00, 8'h00, 8'h11));
    dir_rows.push_back(mk_req(ROW_TYPED, OP_HELD, 1, 1, 30, 0, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_RELEASED, 1, 1, 30, 0, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_RELEASED, 1, 1, 100, 0, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_RELEASED, 1, 1, 0, 0, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(mk_req(ROW_TYPED, OP_HELD, 7, 7, 255, 0, 8'h00, 8'h00, 8'hFF));
    // Pins with no rule at all
    dir_rows.push_back(mk_req(ROW_TYPED, OP_RELEASED, 0, 0, 5, 0, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(mk_req(ROW_TYPED, OP_RELEASED, 7, 6, 255, 0, 8'h00, 8'h00, 8'h00));
    // Threshold extremes: short from zero, medium and long only at the top
    dir_rows.push_back(mk_cfg(CFG_SHORT_TICKS, 8'd0));
    dir_rows.push_back(mk_cfg(CFG_MEDIUM_TICKS, 8'd255));
    dir_rows.push_back(mk_cfg(CFG_LONG_TICKS, 8'd255));
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_HELD, 1, 1, 0, 0, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_RELEASED, 7, 7, 254, 0, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_RELEASED, 7, 7, 255, 0, 8'h00, 8'h00, 8'h00));
    // Long from zero: every press is long
    dir_rows.push_back(mk_cfg(CFG_LONG_TICKS, 8'd0));
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_RELEASED, 1, 1, 0, 0, 8'h00, 8'h00, 8'h00));
    // Shrink the count so the long rules fall outside it
    dir_rows.push_back(mk_cfg(CFG_RULE_COUNT, 8'd2));
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_HELD, 7, 7, 255, 0, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(mk_req(ROW_PREDICT, OP_RELEASED, 1, 1, 200, 0, 8'h00, 8'h00, 8'h00));

    // Hold reset, then release it on a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed rows; register writes wait for the block to go idle
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        sender_gap();
        send_req(dir_rows[i].req, dir_rows[i].kind == ROW_TYPED, dir_rows[i].want);
      end
    end

    // Random phases; each draws its own idling mix, and the tail runs flat out
    while (rand_items < RAND_ITEMS) begin
      wait_idle();
      if (rand_items >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 15;
        default: stall_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 35;
      endcase
      random_phase();
    end

    // Drain: every owed action back, then an idle spell for stragglers
    wait_idle();

    $display("covered %0d held and %0d released requests, %0d rule loads, %0d register settings",
             n_held, n_released, n_loads, n_phases);
    $display("checked %0d actions in %0d cycles, %0d mismatches",
             n_checked, cycle_count, err_count);
    if (err_count == 0) begin
      $display("button_press_rule_matcher_tb passed");
    end else begin
      $display("button_press_rule_matcher_tb failed");
    end
    $finish;
  end

endmodule
